// ----- rtl/core/cws_pkg.sv -----
// Shared types and constants for the channel to wire segments unit.
`timescale 1ns / 1ps
`default_nettype none
package cws_pkg;

  localparam int ChanW = 24;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] RegAnchU = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAnchV = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAnchZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWireU = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWireV = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWireZ = 3'd5;
  localparam logic [CfgIdxW-1:0] RegChamb = 3'd6;
  localparam logic [CfgIdxW-1:0] RegCryo = 3'd7;

  // One decoded channel, passed from front to back.
  typedef struct packed {
    logic        illegal;
    logic [3:0]  cryostat;
    logic [7:0]  base_ch;
    logic [1:0]  plane;
    logic        flip;
    logic [11:0] bottom;
    logic [9:0]  anch;
    logic [11:0] nw;
  } job_t;

  // One result segment.
  typedef struct packed {
    logic [3:0]  cryostat;
    logic [7:0]  chamber;
    logic [1:0]  plane;
    logic [11:0] wire_res;
    logic        last;
    logic        illegal;
  } seg_t;

endpackage
`default_nettype wire

// ----- rtl/core/cws_if.sv -----
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface cws_chan_if;
  logic        valid;
  logic        ready;
  logic [23:0] channel;
  modport source(output valid, output channel, input ready);
  modport sink(input valid, input channel, output ready);
endinterface

interface cws_seg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cryostat;
  logic [7:0]  chamber;
  logic [1:0]  plane;
  logic [11:0] wire_res;
  logic        last;
  logic        illegal;
  modport source(output valid, output cryostat, output chamber, output plane,
                 output wire_res, output last, output illegal, input ready);
  modport sink(input valid, input cryostat, input chamber, input plane,
               input wire_res, input last, input illegal, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/channel_to_wire_segments_unit.sv -----
// Top level of the channel to wire segments unit.
// Maps a readout channel number to every wire segment it reads. The registers
// hold the anchored wire counts, the wire counts, chambers per cryostat and the
// cryostat count; write them only while no request is in flight. A request is
// decoded by a shared one-bit-per-cycle divider: channel / channels per frame,
// frame / frames per cryostat and 2*frame mod chambers, in that order. The
// decoded channel is then handed to the back end, which registers it before it
// offers the first segment; segments then leave one per cycle while the result
// side is ready, last set on the final one. A channel past the total count gives
// one result with illegal set, decoded after the second division (with no
// division when the geometry holds no channels). The front end takes the next
// request while the back end still emits segments, but only after handing the
// previous decoded channel on, later while the back end holds a decoded channel.
`timescale 1ns / 1ps
`default_nettype none
module channel_to_wire_segments_unit #(
  parameter int MAX_SEGMENTS = 50,
  parameter int PLANES = 3
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [cws_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cws_pkg::CfgDataW-1:0] cfg_data_i,
  cws_chan_if.sink                      in_if,
  cws_seg_if.source                     out_if
);
  import cws_pkg::*;

  logic [9:0]  anch_q [3];
  logic [11:0] wires_q [3];
  logic [7:0]  chamb_q;
  logic [4:0]  cryo_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anch_q[0] <= 10'd1; anch_q[1] <= 10'd1; anch_q[2] <= 10'd1;
      wires_q[0] <= 12'd1; wires_q[1] <= 12'd1; wires_q[2] <= 12'd1;
      chamb_q <= 8'd2; cryo_q <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAnchU: anch_q[0] <= cfg_data_i[9:0];
        RegAnchV: anch_q[1] <= cfg_data_i[9:0];
        RegAnchZ: anch_q[2] <= cfg_data_i[9:0];
        RegWireU: wires_q[0] <= cfg_data_i;
        RegWireV: wires_q[1] <= cfg_data_i;
        RegWireZ: wires_q[2] <= cfg_data_i;
        RegChamb: chamb_q <= cfg_data_i[7:0];
        RegCryo:  cryo_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic  job_valid, job_ready;
  job_t  job;
  seg_t  seg;

  cws_front #(.PLANES(PLANES)) u_front (
    .clk_i, .rst_ni, .anch_i(anch_q), .wires_i(wires_q), .chambers_i(chamb_q),
    .cryo_cnt_i(cryo_q), .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .channel_i(in_if.channel), .job_valid_o(job_valid), .job_ready_i(job_ready),
    .job_o(job));

  cws_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .seg_valid_o(out_if.valid), .seg_ready_i(out_if.ready), .seg_o(seg));

  assign out_if.cryostat = seg.cryostat;
  assign out_if.chamber  = seg.chamber;
  assign out_if.plane    = seg.plane;
  assign out_if.wire_res = seg.wire_res;
  assign out_if.last     = seg.last;
  assign out_if.illegal  = seg.illegal;

  a_ill_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.illegal |-> !out_if.last && out_if.wire_res == 12'd0)
    else $error("illegal result carries data");
  a_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.plane != 2'd3) else $error("bad plane");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && !job_ready |=> job_valid) else $error("job dropped");
endmodule
`default_nettype wire

// ----- rtl/core/cws_front.sv -----
// Front end: decodes a channel into frame, cryostat, base chamber, plane, group and bottom wire.
`timescale 1ns / 1ps
`default_nettype none
module cws_front #(
  parameter int PLANES = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [9:0]          anch_i [3],
  input  wire logic [11:0]         wires_i [3],
  input  wire logic [7:0]          chambers_i,
  input  wire logic [4:0]          cryo_cnt_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [23:0]         channel_i,
  output logic                     job_valid_o,
  input  wire logic                job_ready_i,
  output cws_pkg::job_t            job_o
);
  import cws_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDivF = 3'd1;  // channel / cpf
  localparam logic [2:0] StDivC = 3'd2;  // frame / frames
  localparam logic [2:0] StDivB = 3'd3;  // 2*frame mod chambers
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]  state_q, state_d;
  // shared restoring divider
  logic [23:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [23:0] frame_q, frame_d;
  logic [12:0] off_q, off_d;
  job_t        job_q, job_d;

  logic [12:0] cpf;
  logic [6:0]  frames;
  logic [12:0] first1, first2;
  logic [24:0] trial;
  logic [23:0] rem_sh, rem_nx, quo_nx;
  logic [1:0]  pl;
  logic [11:0] win;
  logic [9:0]  a0, a1, a2;
  logic [9:0]  anch_sel;
  logic        grp;
  logic [11:0] bottom;

  always_comb begin
    a0 = anch_i[0];
    a1 = (PLANES > 1) ? anch_i[1] : 10'd0;
    a2 = (PLANES > 2) ? anch_i[2] : 10'd0;
    cpf = {2'b0, a0, 1'b0} + {2'b0, a1, 1'b0} + {2'b0, a2, 1'b0};
    frames = chambers_i[7:1];
    first1 = {2'b0, a0, 1'b0};
    first2 = first1 + {2'b0, a1, 1'b0};
  end

  // one divider step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_q[22:0], quo_q[23]};
    trial = {1'b0, rem_sh} - {1'b0, dvs_q};
    rem_nx = trial[24] ? rem_sh : trial[23:0];
    quo_nx = {quo_q[22:0], ~trial[24]};
  end

  // plane select from offset; the group is the frame side (0 or 1)
  always_comb begin
    if (off_q < first1) begin
      pl = 2'd0; win = off_q[11:0];
    end else if (off_q < first2) begin
      pl = 2'd1; win = 12'(off_q - first1);
    end else begin
      pl = 2'd2; win = 12'(off_q - first2);
    end
    anch_sel = (pl == 2'd0) ? a0 : (pl == 2'd1) ? a1 : a2;
    grp = (win >= 12'(anch_sel));
    bottom = grp ? win - 12'(anch_sel) : win;
  end

  // decode sequence; a quotient of frame / frames at or above the cryostat
  // count means the channel is past the total
  always_comb begin
    state_d = state_q; rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    frame_d = frame_q; off_d = off_q; job_d = job_q;
    in_ready_o = (state_q == StIdle);
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        if (cpf == 13'd0 || frames == 7'd0) begin
          job_d = '0; job_d.illegal = 1'b1; state_d = StOut;
        end else begin
          rem_d = '0; quo_d = channel_i; dvs_d = 24'(cpf); cnt_d = '0;
          state_d = StDivF;
        end
      end
      StDivF, StDivC, StDivB: begin
        rem_d = rem_nx; quo_d = quo_nx;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd23) begin
          cnt_d = '0; rem_d = '0;
          if (state_q == StDivF) begin
            frame_d = quo_nx; off_d = rem_nx[12:0]; dvs_d = 24'(frames);
            state_d = StDivC;
          end else if (state_q == StDivC) begin
            if (quo_nx >= 24'(cryo_cnt_i)) begin
              job_d = '0; job_d.illegal = 1'b1; state_d = StOut;
            end else begin
              job_d.illegal = 1'b0;
              job_d.cryostat = quo_nx[3:0];
              job_d.plane = pl;
              job_d.flip = grp;
              job_d.bottom = bottom;
              job_d.anch = anch_sel;
              job_d.nw = wires_i[pl];
              quo_d = {frame_q[22:0], 1'b0}; dvs_d = 24'(chambers_i);
              state_d = StDivB;
            end
          end else begin
            job_d.base_ch = rem_nx[7:0];
            state_d = StOut;
          end
        end
      end
      StOut: if (job_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d; cnt_q <= cnt_d;
    frame_q <= frame_d; off_q <= off_d; job_q <= job_d;
  end

  assign job_valid_o = (state_q == StOut);
  assign job_o = job_q;

endmodule
`default_nettype wire

// ----- rtl/core/cws_back.sv -----
// Back end: steps through the wire segments of one decoded channel.
`timescale 1ns / 1ps
`default_nettype none
module cws_back #(
  parameter int MAX_SEGMENTS = 50
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      job_valid_i,
  output logic           job_ready_o,
  input  wire cws_pkg::job_t job_i,
  output logic           seg_valid_o,
  input  wire logic      seg_ready_i,
  output cws_pkg::seg_t  seg_o
);
  import cws_pkg::*;
  localparam int KW = $clog2(MAX_SEGMENTS + 1);

  logic          busy_q;
  job_t          job_q;
  logic [KW-1:0] k_q;
  logic [12:0]   w_q;
  logic [12:0]   w_next;
  logic          stop;

  assign w_next = w_q + 13'(job_q.anch);
  assign stop = job_q.illegal || (w_next >= 13'(job_q.nw)) ||
                (32'(k_q) + 1 >= MAX_SEGMENTS);
  assign job_ready_o = !busy_q;
  assign seg_valid_o = busy_q;

  always_comb begin
    seg_o = '0;
    seg_o.illegal = job_q.illegal;
    if (!job_q.illegal) begin
      seg_o.cryostat = job_q.cryostat;
      seg_o.chamber = job_q.base_ch + 8'(k_q[0] ^ job_q.flip);
      seg_o.plane = job_q.plane;
      seg_o.wire_res = w_q[11:0];
      seg_o.last = stop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b0;
    else if (!busy_q) busy_q <= job_valid_i;
    else if (seg_ready_i && stop) busy_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (!busy_q && job_valid_i) begin
      job_q <= job_i; k_q <= '0; w_q <= 13'(job_i.bottom);
    end else if (busy_q && seg_ready_i) begin
      k_q <= k_q + KW'(1); w_q <= w_next;
    end
  end
endmodule
`default_nettype wire
